// ===== rtl/core/mcss_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mcss_pkg
// shared constants, operation codes and handshake structs of the markov chain
// state sampler
// ----------------------------------------------------------------------------
package mcss_pkg;

  // chain size and fixed-point format
  localparam int NUM_STATES  = 16;
  localparam int PROB_BITS   = 16;
  localparam int RAND_BITS   = 16;

  // field widths
  localparam int OP_W        = 2;
  localparam int STATE_W     = 4;
  localparam int PROB_W      = PROB_BITS + 1;
  localparam int LAG_W       = 16;
  localparam int STEP_W      = 16;
  localparam int TIME_W      = 32;

  // transition table geometry
  localparam int TABLE_DEPTH = NUM_STATES * NUM_STATES;
  localparam int ADDR_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  // running row sum and the scaled compare
  localparam int SUM_W       = PROB_W + STATE_W;
  localparam int CMP_W       = SUM_W + RAND_BITS;

  // stream payload widths, padded to whole bytes
  localparam int S_FIELDS_W  = 2 * STATE_W + PROB_W + STATE_W + RAND_BITS;
  localparam int S_DATA_W    = ((S_FIELDS_W + 7) / 8) * 8;
  localparam int M_FIELDS_W  = STATE_W + TIME_W;
  localparam int M_DATA_W    = ((M_FIELDS_W + 7) / 8) * 8;

  localparam logic [PROB_W-1:0] PROB_ONE = PROB_W'(1) << PROB_BITS;
  localparam logic [STEP_W-1:0] STEP_MAX = '1;
  localparam logic [LAG_W-1:0]  LAG_RESET = LAG_W'(1);

  typedef enum logic [OP_W-1:0] {
    OP_LOAD = 2'd0,
    OP_SET  = 2'd1,
    OP_STEP = 2'd2,
    OP_NONE = 2'd3
  } op_e;

  typedef struct packed {
    logic                 we;
    logic [ADDR_W-1:0]    addr;
    logic [PROB_W-1:0]    data;
  } tbl_wr_t;

  typedef struct packed {
    logic                 start;
    logic [STATE_W-1:0]   row;
    logic [RAND_BITS-1:0] rnd;
  } walk_req_t;

  typedef struct packed {
    logic                 done;
    logic                 found;
    logic [STATE_W-1:0]   col;
  } walk_rsp_t;

endpackage
`default_nettype wire

// ===== rtl/core/mcss_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mcss_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module mcss_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

// ===== rtl/core/mcss_row_walker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mcss_row_walker
// holds the transition table and walks one row, one entry per cycle, through
// a shared add and compare unit
// ----------------------------------------------------------------------------
module mcss_row_walker (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire mcss_pkg::tbl_wr_t  wr_i,
  input  wire mcss_pkg::walk_req_t req_i,
  output mcss_pkg::walk_rsp_t     rsp_o
);
  import mcss_pkg::*;

  typedef enum logic {
    W_IDLE,
    W_RUN
  } walk_state_e;

  walk_state_e          state_q;
  logic [STATE_W-1:0]   row_q;
  logic [RAND_BITS-1:0] rnd_q;
  logic [STATE_W-1:0]   rd_idx_q;
  logic [STATE_W-1:0]   rd_idx_d;
  logic [STATE_W-1:0]   chk_idx_q;
  logic                 dv_q;
  logic [SUM_W-1:0]     sum_q;
  logic [SUM_W-1:0]     sum_d;
  logic [ADDR_W-1:0]    raddr;
  logic [PROB_W-1:0]    rdata;
  logic [CMP_W-1:0]     lhs;
  logic [CMP_W-1:0]     rhs;
  logic                 hit;
  logic                 row_end;

  mcss_ram #(
    .WIDTH (PROB_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (wr_i.we),
    .waddr_i (wr_i.addr),
    .wdata_i (wr_i.data),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign raddr    = ADDR_W'(row_q) * ADDR_W'(NUM_STATES) + ADDR_W'(rd_idx_q);
  assign rd_idx_d = (32'(rd_idx_q) == NUM_STATES - 1) ? '0 : rd_idx_q + 1'b1;

  // shared unit: accumulate and compare r * 2^prob_bits against sum * 2^rand_bits
  assign sum_d   = sum_q + SUM_W'(rdata);
  assign lhs     = CMP_W'(rnd_q) << PROB_BITS;
  assign rhs     = CMP_W'(sum_d) << RAND_BITS;
  assign hit     = (lhs <= rhs);
  assign row_end = (32'(chk_idx_q) == NUM_STATES - 1);

  assign rsp_o.done  = (state_q == W_RUN) && dv_q && (hit || row_end);
  assign rsp_o.found = hit;
  assign rsp_o.col   = chk_idx_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= W_IDLE;
      row_q     <= '0;
      rnd_q     <= '0;
      rd_idx_q  <= '0;
      chk_idx_q <= '0;
      dv_q      <= 1'b0;
      sum_q     <= '0;
    end else begin
      case (state_q)
        W_IDLE: begin
          dv_q <= 1'b0;
          if (req_i.start) begin
            row_q    <= req_i.row;
            rnd_q    <= req_i.rnd;
            rd_idx_q <= '0;
            sum_q    <= '0;
            state_q  <= W_RUN;
          end
        end
        W_RUN: begin
          // reads run one entry ahead of the compare
          rd_idx_q  <= rd_idx_d;
          chk_idx_q <= rd_idx_q;
          if (dv_q && (hit || row_end)) begin
            dv_q    <= 1'b0;
            state_q <= W_IDLE;
          end else begin
            dv_q <= 1'b1;
          end
          if (dv_q) begin
            sum_q <= sum_d;
          end
        end
        default: begin
          state_q <= W_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/markov_chain_state_sampler.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// markov_chain_state_sampler
// discrete-time markov chain stepped by inverse-cdf sampling over a loaded
// fixed-point transition table
// ----------------------------------------------------------------------------
// Each input request carries an operation in tuser: load one table entry, set
// the chain state (which also clears the step count), or take one step with a
// uniform draw. Every request returns exactly one result with the chain state
// after it. A step walks the current state's row from column 0, one table
// entry per cycle through a single adder and comparator, and moves to the
// first column whose running sum reaches the draw; found is low and the state
// is kept if none does. When tlast marks the final step of a run the result
// carries tlast and elapsed_time = lag_time * steps since set-state (steps
// saturate at 65535). Loads, set-state and the unused operation need no walk
// and their result is shown in the next cycle. A step walks the row at one
// table read per cycle behind the registered read of the table ram, then
// registers the lag multiply into the result in the S_MUL state. A new request
// is taken only once the previous result has been handed off. lag_time is
// written on the cfg port and resets to 1; write it only while the block is
// idle. Table entries read before they are loaded return unspecified data.
// ----------------------------------------------------------------------------
module markov_chain_state_sampler (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // input request stream
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  // row_index[3:0], column_index[7:4], probability[24:8], state_value[28:25],
  // random_value[44:29], zero pad[47:45]
  input  wire logic [mcss_pkg::S_DATA_W-1:0] s_axis_tdata,
  // operation[1:0]
  input  wire logic [mcss_pkg::OP_W-1:0]     s_axis_tuser,
  // last_step
  input  wire logic                          s_axis_tlast,
  // result stream
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  // current_state[3:0], elapsed_time[35:4], zero pad[39:36]
  output logic      [mcss_pkg::M_DATA_W-1:0] m_axis_tdata,
  // found[0]
  output logic      [0:0]                    m_axis_tuser,
  // run_done
  output logic                               m_axis_tlast,
  // lag_time register write
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [mcss_pkg::LAG_W-1:0]    cfg_data_i
);
  import mcss_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_MUL
  } ctrl_state_e;

  ctrl_state_e          state_q;
  logic [STATE_W-1:0]   chain_q;
  logic [STEP_W-1:0]    steps_q;
  logic [LAG_W-1:0]     lag_q;
  logic                 last_q;
  logic                 found_q;

  // output register
  logic                 out_valid_q;
  logic [STATE_W-1:0]   out_state_q;
  logic                 out_found_q;
  logic                 out_done_q;
  logic [TIME_W-1:0]    out_time_q;

  // unpacked request fields
  op_e                  in_op;
  logic [STATE_W-1:0]   in_row;
  logic [STATE_W-1:0]   in_col;
  logic [PROB_W-1:0]    in_prob;
  logic [STATE_W-1:0]   in_sval;
  logic [RAND_BITS-1:0] in_rnd;

  logic                 in_acc;
  logic                 out_acc;
  logic                 load_ok;
  logic [PROB_W-1:0]    prob_sat;
  logic [STATE_W-1:0]   sval_clamp;
  logic [STEP_W-1:0]    steps_inc;

  tbl_wr_t              tbl_wr;
  walk_req_t            walk_req;
  walk_rsp_t            walk_rsp;

  assign in_op   = op_e'(s_axis_tuser);
  assign in_row  = s_axis_tdata[STATE_W-1:0];
  assign in_col  = s_axis_tdata[2*STATE_W-1:STATE_W];
  assign in_prob = s_axis_tdata[2*STATE_W+PROB_W-1:2*STATE_W];
  assign in_sval = s_axis_tdata[3*STATE_W+PROB_W-1:2*STATE_W+PROB_W];
  assign in_rnd  = s_axis_tdata[3*STATE_W+PROB_W+RAND_BITS-1:3*STATE_W+PROB_W];

  assign s_axis_tready = (state_q == S_IDLE) && !out_valid_q;
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign out_acc       = out_valid_q && m_axis_tready;
  assign cfg_ready_o   = 1'b1;

  // loads outside the table are dropped, values above one saturate
  assign load_ok    = (32'(in_row) < NUM_STATES) && (32'(in_col) < NUM_STATES);
  assign prob_sat   = (in_prob > PROB_ONE) ? PROB_ONE : in_prob;
  assign sval_clamp = (32'(in_sval) < NUM_STATES) ? in_sval : STATE_W'(NUM_STATES - 1);
  assign steps_inc  = (steps_q == STEP_MAX) ? steps_q : steps_q + 1'b1;

  always_comb begin
    tbl_wr.we   = in_acc && (in_op == OP_LOAD) && load_ok;
    tbl_wr.addr = ADDR_W'(in_row) * ADDR_W'(NUM_STATES) + ADDR_W'(in_col);
    tbl_wr.data = prob_sat;
  end

  // the walk starts in the accept cycle, on the current chain state's row
  always_comb begin
    walk_req.start = in_acc && (in_op == OP_STEP);
    walk_req.row   = chain_q;
    walk_req.rnd   = in_rnd;
  end

  mcss_row_walker u_walker (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .wr_i   (tbl_wr),
    .req_i  (walk_req),
    .rsp_o  (walk_rsp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      chain_q     <= '0;
      steps_q     <= '0;
      lag_q       <= LAG_RESET;
      last_q      <= 1'b0;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
      out_state_q <= '0;
      out_found_q <= 1'b0;
      out_done_q  <= 1'b0;
      out_time_q  <= '0;
    end else begin
      if (cfg_valid_i) begin
        lag_q <= cfg_data_i;
      end
      if (out_acc) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            out_found_q <= 1'b0;
            out_done_q  <= 1'b0;
            out_time_q  <= '0;
            case (in_op)
              OP_SET: begin
                chain_q     <= sval_clamp;
                steps_q     <= '0;
                out_state_q <= sval_clamp;
                out_valid_q <= 1'b1;
              end
              OP_STEP: begin
                last_q  <= s_axis_tlast;
                state_q <= S_WALK;
              end
              default: begin
                // table load and the unused operation report the state as is
                out_state_q <= chain_q;
                out_valid_q <= 1'b1;
              end
            endcase
          end
        end
        S_WALK: begin
          if (walk_rsp.done) begin
            if (walk_rsp.found) begin
              chain_q <= walk_rsp.col;
            end
            found_q <= walk_rsp.found;
            steps_q <= steps_inc;
            state_q <= S_MUL;
          end
        end
        S_MUL: begin
          // elapsed time uses the already incremented step count
          out_state_q <= chain_q;
          out_found_q <= found_q;
          out_done_q  <= last_q;
          out_time_q  <= last_q ? (TIME_W'(lag_q) * TIME_W'(steps_q)) : '0;
          out_valid_q <= 1'b1;
          state_q     <= S_IDLE;
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = M_DATA_W'({out_time_q, out_state_q});
  assign m_axis_tuser  = out_found_q;
  assign m_axis_tlast  = out_done_q;

endmodule
`default_nettype wire
